// ===== design/rrt_pkg.sv =====
// rrt_pkg: shared types and constants for the refresh request throttle.
// Holds status and command codes, register indexes and the result word layout.
// No dependencies.
`timescale 1ns / 1ps

package rrt_pkg;

  // Fixed field widths
  localparam int TIME_W     = 48;
  localparam int INTERVAL_W = 16;
  localparam int ANIM_W     = 4;
  localparam int FIELD_W    = 32;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  // Event counter slots
  localparam int NUM_CNT  = 5;
  localparam int CNT_REQ  = 0;
  localparam int CNT_COAL = 1;
  localparam int CNT_LIM  = 2;
  localparam int CNT_ACC  = 3;
  localparam int CNT_CONS = 4;

  typedef enum logic [2:0] {
    ST_INACTIVE  = 3'd0,
    ST_COALESCED = 3'd1,
    ST_LIMITED   = 3'd2,
    ST_ACCEPTED  = 3'd3,
    ST_CONSUMED  = 3'd4,
    ST_NOTHING   = 3'd5
  } status_t;

  typedef enum logic {
    CMD_REQUEST = 1'b0,
    CMD_CONSUME = 1'b1
  } cmd_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_GATE     = 2'd0,
    REG_INTERVAL = 2'd1,
    REG_ANIM     = 2'd2
  } reg_idx_t;

  typedef struct packed {
    logic                  valid;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;
  } cfg_wr_t;

  typedef struct packed {
    status_t              status;
    logic                 pending_now;
    logic [FIELD_W-1:0]   requested_count;
    logic [FIELD_W-1:0]   coalesced_count;
    logic [FIELD_W-1:0]   limited_count;
    logic [FIELD_W-1:0]   accepted_count;
    logic [FIELD_W-1:0]   consumed_count;
    logic                 peak_pending;
  } result_t;

endpackage

// ===== design/rrt_if.sv =====
// rrt_if: valid/ready channel interfaces for the refresh request throttle.
// Request, result and configuration channels. Depends on rrt_pkg.
`timescale 1ns / 1ps

interface rrt_req_if;
  import rrt_pkg::*;
  logic              valid;
  logic              ready;
  logic              cmd;
  logic [TIME_W-1:0] time_ms;
  modport source (output valid, output cmd, output time_ms, input ready);
  modport sink   (input valid, input cmd, input time_ms, output ready);
endinterface

interface rrt_rsp_if;
  import rrt_pkg::*;
  logic               valid;
  logic               ready;
  logic [2:0]         status;
  logic               pending_now;
  logic [FIELD_W-1:0] requested_count;
  logic [FIELD_W-1:0] coalesced_count;
  logic [FIELD_W-1:0] limited_count;
  logic [FIELD_W-1:0] accepted_count;
  logic [FIELD_W-1:0] consumed_count;
  logic               peak_pending;
  modport source (output valid, output status, output pending_now,
                  output requested_count, output coalesced_count,
                  output limited_count, output accepted_count,
                  output consumed_count, output peak_pending, input ready);
  modport sink   (input valid, input status, input pending_now,
                  input requested_count, input coalesced_count,
                  input limited_count, input accepted_count,
                  input consumed_count, input peak_pending, output ready);
endinterface

interface rrt_cfg_if;
  import rrt_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== design/rrt_core.sv =====
// rrt_core: decision logic, configuration registers, mark and event counters.
// Steps one word per cycle while step is high; returns its result. Uses rrt_pkg.
`timescale 1ns / 1ps

module rrt_core #(
  parameter int INTERVAL_FLOOR_MS = 100,
  parameter int COUNTER_WIDTH     = 32
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   step,
  input  logic                   cmd,
  input  logic [rrt_pkg::TIME_W-1:0] time_ms,
  input  rrt_pkg::cfg_wr_t       cfg,
  output rrt_pkg::result_t       res
);
  import rrt_pkg::*;

  localparam logic [INTERVAL_W-1:0] FLOOR = INTERVAL_W'(INTERVAL_FLOOR_MS);

  // Configuration registers
  logic                  gate_active;
  logic [INTERVAL_W-1:0] min_interval_ms;
  logic [ANIM_W-1:0]     animation_id;

  // Throttle state
  logic                  pending_flag;
  logic                  have_last_mark;
  logic [TIME_W-1:0]     last_accept_time;
  logic                  peak_pending_flag;
  logic [COUNTER_WIDTH-1:0] cnt [NUM_CNT];

  logic                  pending_next;
  logic                  have_last_mark_next;
  logic                  peak_next;
  logic                  mark_load;
  logic                  clear_marks;
  logic [NUM_CNT-1:0]    bump;
  status_t               status;
  logic [INTERVAL_W-1:0] eff_cur;
  logic [INTERVAL_W-1:0] eff_new;
  logic [TIME_W-1:0]     elapsed;
  logic                  too_soon;
  logic [COUNTER_WIDTH-1:0]         cnt_next [NUM_CNT];
  logic [COUNTER_WIDTH+FIELD_W-1:0] cnt_ext  [NUM_CNT];

  // Effective interval, raised to the floor
  assign eff_cur = (min_interval_ms < FLOOR) ? FLOOR : min_interval_ms;
  assign eff_new = (cfg.data < FLOOR) ? FLOOR : cfg.data;

  // Backwards time or short gap since the mark
  assign elapsed  = time_ms - last_accept_time;
  assign too_soon = have_last_mark &&
                    ((time_ms < last_accept_time) ||
                     (elapsed < {{(TIME_W-INTERVAL_W){1'b0}}, eff_cur}));

  // Classify the word
  always_comb begin
    status              = ST_NOTHING;
    bump                = '0;
    pending_next        = pending_flag;
    have_last_mark_next = have_last_mark;
    peak_next           = peak_pending_flag;
    mark_load           = 1'b0;
    if (cmd == CMD_CONSUME) begin
      if (pending_flag) begin
        status         = ST_CONSUMED;
        pending_next   = 1'b0;
        bump[CNT_CONS] = 1'b1;
      end
    end else begin
      bump[CNT_REQ] = 1'b1;
      if (!gate_active) begin
        status = ST_INACTIVE;
      end else if (pending_flag) begin
        status         = ST_COALESCED;
        bump[CNT_COAL] = 1'b1;
      end else if (too_soon) begin
        status        = ST_LIMITED;
        bump[CNT_LIM] = 1'b1;
      end else begin
        status              = ST_ACCEPTED;
        bump[CNT_ACC]       = 1'b1;
        pending_next        = 1'b1;
        have_last_mark_next = 1'b1;
        peak_next           = 1'b1;
        mark_load           = 1'b1;
      end
    end
  end

  // Saturating counter increments
  always_comb begin
    for (int i = 0; i < NUM_CNT; i++) begin
      cnt_next[i] = (bump[i] && (cnt[i] != '1)) ? cnt[i] + 1'b1 : cnt[i];
      cnt_ext[i]  = {{FIELD_W{1'b0}}, cnt_next[i]};
    end
  end

  // Decide whether a register write drops the pending refresh and mark
  always_comb begin
    clear_marks = 1'b0;
    if (cfg.valid) begin
      unique case (cfg.index)
        REG_GATE:     clear_marks = !cfg.data[0] || !gate_active;
        REG_INTERVAL: clear_marks = (eff_new != eff_cur);
        REG_ANIM:     clear_marks = (cfg.data[ANIM_W-1:0] != animation_id);
        default:      clear_marks = 1'b0;
      endcase
    end
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      gate_active     <= 1'b0;
      min_interval_ms <= '0;
      animation_id    <= '0;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        REG_GATE:     gate_active     <= cfg.data[0];
        REG_INTERVAL: min_interval_ms <= cfg.data;
        REG_ANIM:     animation_id    <= cfg.data[ANIM_W-1:0];
        default:      ;
      endcase
    end
  end

  // Pending flag, mark and counters
  always_ff @(posedge clk) begin
    if (rst) begin
      pending_flag      <= 1'b0;
      have_last_mark    <= 1'b0;
      last_accept_time  <= '0;
      peak_pending_flag <= 1'b0;
      for (int i = 0; i < NUM_CNT; i++) begin
        cnt[i] <= '0;
      end
    end else if (clear_marks) begin
      pending_flag   <= 1'b0;
      have_last_mark <= 1'b0;
    end else if (step) begin
      pending_flag      <= pending_next;
      have_last_mark    <= have_last_mark_next;
      peak_pending_flag <= peak_next;
      if (mark_load) begin
        last_accept_time <= time_ms;
      end
      for (int i = 0; i < NUM_CNT; i++) begin
        cnt[i] <= cnt_next[i];
      end
    end
  end

  // Result word, low bits of each counter
  always_comb begin
    res.status          = status;
    res.pending_now     = pending_next;
    res.requested_count = cnt_ext[CNT_REQ][FIELD_W-1:0];
    res.coalesced_count = cnt_ext[CNT_COAL][FIELD_W-1:0];
    res.limited_count   = cnt_ext[CNT_LIM][FIELD_W-1:0];
    res.accepted_count  = cnt_ext[CNT_ACC][FIELD_W-1:0];
    res.consumed_count  = cnt_ext[CNT_CONS][FIELD_W-1:0];
    res.peak_pending    = peak_next;
  end

endmodule

// ===== design/rrt_obuf.sv =====
// rrt_obuf: two-entry result buffer (head register plus skid register).
// Lets a new word in while one result still waits downstream. Depends on rrt_pkg.
`timescale 1ns / 1ps

module rrt_obuf (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  rrt_pkg::result_t push_data,
  output logic             space,
  output logic             head_valid,
  input  logic             pop,
  output rrt_pkg::result_t head_data
);
  import rrt_pkg::*;

  logic    v0;
  logic    v1;
  result_t slot0;
  result_t slot1;

  assign space      = !v1;
  assign head_valid = v0;
  assign head_data  = slot0;

  // Occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
      v1 <= 1'b0;
    end else if (pop && !push) begin
      v0 <= v1;
      v1 <= 1'b0;
    end else if (push && !pop) begin
      if (v0) begin
        v1 <= 1'b1;
      end else begin
        v0 <= 1'b1;
      end
    end
  end

  // Payload: advance the skid word on pop, land new words behind it
  always_ff @(posedge clk) begin
    if (pop && push) begin
      if (v1) begin
        slot0 <= slot1;
        slot1 <= push_data;
      end else begin
        slot0 <= push_data;
      end
    end else if (pop) begin
      slot0 <= slot1;
    end else if (push) begin
      if (v0) begin
        slot1 <= push_data;
      end else begin
        slot0 <= push_data;
      end
    end
  end

endmodule

// ===== design/refresh_request_throttle.sv =====
// Refresh request throttle: takes one request or consume word per clock while
// the result buffer has space and returns exactly one result word for each,
// held in a registered result buffer. The whole decision (gate, pending check,
// 48-bit elapsed-time compare against the floored interval) and the counter
// next values are combinational, so the sustained rate is one word per cycle. A
// two-entry result buffer lets the block keep taking words while one result
// waits; input ready drops only when both entries are full. Configuration
// writes are always taken (ready high) and must be issued only while the
// block is idle. Depends on rrt_pkg, rrt_if, rrt_core and rrt_obuf.
`timescale 1ns / 1ps

module refresh_request_throttle #(
  parameter int INTERVAL_FLOOR_MS = 100,
  parameter int COUNTER_WIDTH     = 32
) (
  input logic          clk,
  input logic          rst,
  rrt_req_if.sink      req,
  rrt_rsp_if.source    rsp,
  rrt_cfg_if.sink      cfg
);
  import rrt_pkg::*;

  logic    space;
  logic    step;
  logic    pop;
  cfg_wr_t cfg_wr;
  result_t res;
  result_t head;

  assign req.ready = space;
  assign step      = req.valid && space;
  assign pop       = rsp.valid && rsp.ready;

  // Configuration port never stalls
  assign cfg.ready    = 1'b1;
  assign cfg_wr.valid = cfg.valid;
  assign cfg_wr.index = cfg.index;
  assign cfg_wr.data  = cfg.data;

  rrt_core #(
    .INTERVAL_FLOOR_MS (INTERVAL_FLOOR_MS),
    .COUNTER_WIDTH     (COUNTER_WIDTH)
  ) u_core (
    .clk     (clk),
    .rst     (rst),
    .step    (step),
    .cmd     (req.cmd),
    .time_ms (req.time_ms),
    .cfg     (cfg_wr),
    .res     (res)
  );

  rrt_obuf u_obuf (
    .clk        (clk),
    .rst        (rst),
    .push       (step),
    .push_data  (res),
    .space      (space),
    .head_valid (rsp.valid),
    .pop        (pop),
    .head_data  (head)
  );

  // Unpack the head result word onto the channel
  assign rsp.status          = head.status;
  assign rsp.pending_now     = head.pending_now;
  assign rsp.requested_count = head.requested_count;
  assign rsp.coalesced_count = head.coalesced_count;
  assign rsp.limited_count   = head.limited_count;
  assign rsp.accepted_count  = head.accepted_count;
  assign rsp.consumed_count  = head.consumed_count;
  assign rsp.peak_pending    = head.peak_pending;

endmodule

// ===== tb/sv/tb_top.sv =====
// tb_top: self-checking bench for refresh_request_throttle.
// A directed script, then random phases under varied idling, all checked
// word by word against an in-bench throttle predictor. Needs rrt_pkg, rrt_if.
`timescale 1ns / 1ps

module tb_top;
  import rrt_pkg::*;

  localparam int FLOOR_MS    = 100;
  localparam int CNT_W       = 32;
  localparam int PHASES      = 5;
  localparam int PHASE_WORDS = 150;
  localparam int HOLD_CYCLES = 300;
  localparam int CYCLE_LIMIT = 400000;
  localparam logic [TIME_W-1:0]    TIME_MAX  = '1;
  localparam logic [CNT_W-1:0]     CNT_MAX   = '1;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

  typedef enum logic {ROW_WORD, ROW_REG} row_kind_t;

  typedef struct {
    row_kind_t             kind;
    logic [CFG_IDX_W-1:0]  idx;
    logic [CFG_DATA_W-1:0] data;
    cmd_t                  cmd;
    logic [TIME_W-1:0]     tstamp;
    bit                    fixed;
    status_t               st;
    bit                    pend;
  } script_row_t;

  typedef struct {
    bit      fixed;
    status_t st;
    bit      pend;
  } fixed_exp_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  rrt_req_if req_ch ();
  rrt_rsp_if rsp_ch ();
  rrt_cfg_if cfg_ch ();

  refresh_request_throttle #(
    .INTERVAL_FLOOR_MS(FLOOR_MS),
    .COUNTER_WIDTH    (CNT_W)
  ) dut (
    .clk(clk),
    .rst(rst),
    .req(req_ch),
    .rsp(rsp_ch),
    .cfg(cfg_ch)
  );

  // Predictor state: registers, marks and event counters
  logic                  gate_on;
  logic [INTERVAL_W-1:0] interval_reg;
  logic [ANIM_W-1:0]     anim_reg;
  logic                  pend_flag;
  logic                  mark_valid;
  logic [TIME_W-1:0]     mark_time;
  logic [CNT_W-1:0]      event_cnt [NUM_CNT];
  logic                  peak_flag;

  result_t     due_results [$];
  fixed_exp_t  fixed_q [$];
  script_row_t script [$];

  int fault_cnt      = 0;
  int cycle_cnt      = 0;
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int hold_serial    = 0;
  int hold_seen      = 0;
  int hold_left      = 0;

  // Clock: 8 ns period
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic logic [INTERVAL_W-1:0] floor_interval(input logic [INTERVAL_W-1:0] v);
    return (v < FLOOR_MS) ? INTERVAL_W'(FLOOR_MS) : v;
  endfunction

  function automatic void bump(input int slot);
    if (event_cnt[slot] != CNT_MAX) event_cnt[slot] = event_cnt[slot] + 1'b1;
  endfunction

  function automatic void clear_marks();
    pend_flag  = 1'b0;
    mark_valid = 1'b0;
  endfunction

  function automatic void reset_throttle();
    gate_on      = 1'b0;
    interval_reg = '0;
    anim_reg     = '0;
    clear_marks();
    mark_time    = '0;
    peak_flag    = 1'b0;
    for (int i = 0; i < NUM_CNT; i++) event_cnt[i] = '0;
  endfunction

  // Register write as the block sees it; an unknown index is dropped
  function automatic void apply_reg(input logic [CFG_IDX_W-1:0] idx,
                                    input logic [CFG_DATA_W-1:0] d);
    case (idx)
      REG_GATE: begin
        if (!d[0] || !gate_on) clear_marks();
        gate_on = d[0];
      end
      REG_INTERVAL: begin
        if (floor_interval(d[INTERVAL_W-1:0]) != floor_interval(interval_reg)) clear_marks();
        interval_reg = d[INTERVAL_W-1:0];
      end
      REG_ANIM: begin
        if (d[ANIM_W-1:0] != anim_reg) clear_marks();
        anim_reg = d[ANIM_W-1:0];
      end
      default: ;
    endcase
  endfunction

  // Throttle decision for one word, advancing the predictor state
  function automatic result_t gate_decide(input cmd_t c, input logic [TIME_W-1:0] t);
    result_t r;
    status_t st;
    if (c == CMD_CONSUME) begin
      if (!pend_flag) begin
        st = ST_NOTHING;
      end else begin
        pend_flag = 1'b0;
        bump(CNT_CONS);
        st = ST_CONSUMED;
      end
    end else begin
      bump(CNT_REQ);
      if (!gate_on) begin
        st = ST_INACTIVE;
      end else if (pend_flag) begin
        bump(CNT_COAL);
        st = ST_COALESCED;
      end else if (mark_valid &&
                   (t < mark_time || (t - mark_time) < floor_interval(interval_reg))) begin
        bump(CNT_LIM);
        st = ST_LIMITED;
      end else begin
        mark_valid = 1'b1;
        mark_time  = t;
        pend_flag  = 1'b1;
        peak_flag  = 1'b1;
        bump(CNT_ACC);
        st = ST_ACCEPTED;
      end
    end
    r.status          = st;
    r.pending_now     = pend_flag;
    r.requested_count = event_cnt[CNT_REQ][FIELD_W-1:0];
    r.coalesced_count = event_cnt[CNT_COAL][FIELD_W-1:0];
    r.limited_count   = event_cnt[CNT_LIM][FIELD_W-1:0];
    r.accepted_count  = event_cnt[CNT_ACC][FIELD_W-1:0];
    r.consumed_count  = event_cnt[CNT_CONS][FIELD_W-1:0];
    r.peak_pending    = peak_flag;
    return r;
  endfunction

  task automatic note_field(input string fname, input logic [TIME_W-1:0] want_v,
                            input logic [TIME_W-1:0] got_v);
    if (want_v !== got_v) begin
      fault_cnt++;
      if (fault_cnt <= 10)
        $display("mismatch on %s: expected %0d, got %0d", fname, want_v, got_v);
    end
  endtask

  // Watch all three channels; compare each result word with the oldest due one
  always @(posedge clk) begin
    result_t    want;
    result_t    got;
    fixed_exp_t fx;
    if (!rst) begin
      if (rsp_ch.valid && rsp_ch.ready) begin
        got.status          = status_t'(rsp_ch.status);
        got.pending_now     = rsp_ch.pending_now;
        got.requested_count = rsp_ch.requested_count;
        got.coalesced_count = rsp_ch.coalesced_count;
        got.limited_count   = rsp_ch.limited_count;
        got.accepted_count  = rsp_ch.accepted_count;
        got.consumed_count  = rsp_ch.consumed_count;
        got.peak_pending    = rsp_ch.peak_pending;
        if (due_results.size() == 0) begin
          fault_cnt++;
          if (fault_cnt <= 10) $display("result word with nothing due");
        end else begin
          want = due_results.pop_front();
          note_field("status", want.status, got.status);
          note_field("pending_now", want.pending_now, got.pending_now);
          note_field("requested_count", want.requested_count, got.requested_count);
          note_field("coalesced_count", want.coalesced_count, got.coalesced_count);
          note_field("limited_count", want.limited_count, got.limited_count);
          note_field("accepted_count", want.accepted_count, got.accepted_count);
          note_field("consumed_count", want.consumed_count, got.consumed_count);
          note_field("peak_pending", want.peak_pending, got.peak_pending);
          if (fixed_q.size() != 0) begin
            fx = fixed_q.pop_front();
            if (fx.fixed) begin
              note_field("status (script)", fx.st, got.status);
              note_field("pending_now (script)", fx.pend, got.pending_now);
            end
          end
        end
      end
      if (cfg_ch.valid && cfg_ch.ready) apply_reg(cfg_ch.index, cfg_ch.data);
      if (req_ch.valid && req_ch.ready)
        due_results.push_back(gate_decide(cmd_t'(req_ch.cmd), req_ch.time_ms));
    end
  end

  // Result side: random stalls, or a long hold-off when asked for
  always @(posedge clk) begin
    if (hold_serial != hold_seen) begin
      hold_seen     <= hold_serial;
      hold_left     <= HOLD_CYCLES;
      rsp_ch.ready  <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left     <= hold_left - 1;
      rsp_ch.ready  <= 1'b0;
    end else begin
      rsp_ch.ready  <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("refresh_request_throttle verification failed");
      $finish;
    end
  end

  // Offer one word, idling first at random, and hold it until taken
  task automatic send_word(input cmd_t c, input logic [TIME_W-1:0] t, input bit fixed,
                           input status_t st, input bit pend);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      req_ch.valid <= 1'b0;
      @(posedge clk);
    end
    req_ch.valid   <= 1'b1;
    req_ch.cmd     <= c;
    req_ch.time_ms <= t;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    fixed_q.push_back('{fixed, st, pend});
  endtask

  // Drop the request line and wait until every due result has arrived
  task automatic quiesce();
    req_ch.valid <= 1'b0;
    do @(posedge clk); while (due_results.size() != 0);
    repeat (2) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] d);
    quiesce();
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= d;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  function automatic script_row_t word_row(input cmd_t c, input logic [TIME_W-1:0] t,
                                           input bit fixed, input status_t st, input bit pend);
    return '{ROW_WORD, '0, '0, c, t, fixed, st, pend};
  endfunction

  function automatic script_row_t reg_row(input logic [CFG_IDX_W-1:0] idx,
                                          input logic [CFG_DATA_W-1:0] d);
    return '{ROW_REG, idx, d, CMD_REQUEST, '0, 1'b0, ST_INACTIVE, 1'b0};
  endfunction

  // Gate word: mostly on, upper bits random
  function automatic logic [CFG_DATA_W-1:0] gate_word();
    return {15'($urandom), 1'($urandom_range(0, 9) != 0)};
  endfunction

  // Interval choice: extremes, around the floor, small values, anything
  function automatic logic [CFG_DATA_W-1:0] pick_interval();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return '1;
      2:       return 16'($urandom_range(FLOOR_MS - 1, FLOOR_MS + 1));
      5:       return 16'($urandom);
      default: return 16'($urandom_range(0, 400));
    endcase
  endfunction

  initial begin
    script_row_t       row;
    logic [TIME_W-1:0] cursor;
    logic [TIME_W-1:0] tval;
    logic [CFG_IDX_W-1:0] ridx;
    logic [CFG_DATA_W-1:0] rdata;
    int eff;
    int roll;

    reset_throttle();
    req_ch.valid   <= 1'b0;
    req_ch.cmd     <= CMD_REQUEST;
    req_ch.time_ms <= '0;
    cfg_ch.valid   <= 1'b0;
    cfg_ch.index   <= REG_GATE;
    cfg_ch.data    <= '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed script: reset state, every status, the clearing rules, extremes
    script.push_back(word_row(CMD_REQUEST, '0, 1, ST_INACTIVE, 0));
    script.push_back(word_row(CMD_CONSUME, TIME_MAX, 1, ST_NOTHING, 0));
    script.push_back(reg_row(REG_GATE, 16'h0001));
    script.push_back(word_row(CMD_REQUEST, '0, 1, ST_ACCEPTED, 1));
    script.push_back(word_row(CMD_REQUEST, TIME_MAX, 1, ST_COALESCED, 1));
    script.push_back(word_row(CMD_CONSUME, '0, 1, ST_CONSUMED, 0));
    script.push_back(word_row(CMD_CONSUME, '0, 1, ST_NOTHING, 0));
    script.push_back(word_row(CMD_REQUEST, 48'd99, 1, ST_LIMITED, 0));
    script.push_back(word_row(CMD_REQUEST, 48'd100, 1, ST_ACCEPTED, 1));
    script.push_back(word_row(CMD_CONSUME, TIME_MAX, 1, ST_CONSUMED, 0));
    // equal time, then time going backwards
    script.push_back(word_row(CMD_REQUEST, 48'd100, 1, ST_LIMITED, 0));
    script.push_back(word_row(CMD_REQUEST, 48'd50, 1, ST_LIMITED, 0));
    // interval below the floor leaves the effective value alone
    script.push_back(reg_row(REG_INTERVAL, 16'd50));
    script.push_back(word_row(CMD_REQUEST, 48'd150, 1, ST_LIMITED, 0));
    script.push_back(reg_row(REG_INTERVAL, 16'hFFFF));
    script.push_back(word_row(CMD_REQUEST, 48'd200, 1, ST_ACCEPTED, 1));
    script.push_back(word_row(CMD_CONSUME, '0, 0, ST_INACTIVE, 0));
    script.push_back(word_row(CMD_REQUEST, 48'd65734, 0, ST_INACTIVE, 0));
    script.push_back(word_row(CMD_REQUEST, 48'd65735, 0, ST_INACTIVE, 0));
    // gate rewritten on keeps the pending refresh
    script.push_back(reg_row(REG_GATE, 16'hFFFF));
    script.push_back(word_row(CMD_REQUEST, 48'd1, 1, ST_COALESCED, 1));
    // animation change clears, the same id does not
    script.push_back(reg_row(REG_ANIM, 16'hFFFF));
    script.push_back(word_row(CMD_REQUEST, 48'd5, 1, ST_ACCEPTED, 1));
    script.push_back(reg_row(REG_ANIM, 16'h000F));
    script.push_back(word_row(CMD_REQUEST, TIME_MAX, 1, ST_COALESCED, 1));
    script.push_back(reg_row(REG_SPARE, 16'hFFFF));
    script.push_back(word_row(CMD_REQUEST, TIME_MAX, 1, ST_COALESCED, 1));
    // gate off clears, gate back on clears again
    script.push_back(reg_row(REG_GATE, 16'hFFFE));
    script.push_back(word_row(CMD_REQUEST, '0, 1, ST_INACTIVE, 0));
    script.push_back(reg_row(REG_GATE, 16'h0001));
    script.push_back(word_row(CMD_CONSUME, '0, 1, ST_NOTHING, 0));
    script.push_back(reg_row(REG_INTERVAL, 16'h0000));
    script.push_back(word_row(CMD_REQUEST, TIME_MAX, 1, ST_ACCEPTED, 1));

    foreach (script[i]) begin
      row = script[i];
      if (row.kind == ROW_REG) write_reg(row.idx, row.data);
      else send_word(row.cmd, row.tstamp, row.fixed, row.st, row.pend);
    end

    // Random phases: no idling, sender idle, receiver stall, both, long hold-off
    for (int ph = 0; ph < PHASES; ph++) begin
      send_idle_pct  = (ph == 1) ? 76 : (ph == 3) ? 6 : 0;
      recv_stall_pct <= (ph == 2) ? 76 : (ph == 3) ? 6 : 0;
      write_reg(REG_GATE, gate_word());
      write_reg(REG_INTERVAL, pick_interval());
      write_reg(REG_ANIM, 16'($urandom));
      cursor = (ph == 2) ? TIME_MAX - 48'd5000 : {16'($urandom), 32'($urandom)};
      for (int n = 0; n < PHASE_WORDS; n++) begin
        // pause mid-phase until drained, then write one register (any index, spare included)
        if (n == PHASE_WORDS / 2) begin
          ridx  = 2'($urandom_range(0, 3));
          rdata = (ridx == REG_GATE) ? gate_word() :
                  (ridx == REG_INTERVAL) ? pick_interval() : 16'($urandom);
          write_reg(ridx, rdata);
        end
        if (ph == PHASES - 1 && n == 10) hold_serial <= hold_serial + 1;
        eff  = floor_interval(interval_reg);
        roll = $urandom_range(0, 99);
        if (roll < 30) begin
          send_word(CMD_CONSUME, {16'($urandom), 32'($urandom)}, 0, ST_INACTIVE, 0);
        end else begin
          if (roll < 85) begin
            cursor = cursor + TIME_W'($urandom_range(0, 2 * eff + 1));
            tval   = cursor;
          end else if (roll < 92) begin
            tval = cursor - TIME_W'($urandom_range(0, eff));
          end else begin
            tval = {16'($urandom), 32'($urandom)};
          end
          send_word(CMD_REQUEST, tval, 0, ST_INACTIVE, 0);
        end
      end
    end

    quiesce();
    if (fault_cnt == 0 && due_results.size() == 0) begin
      $display("refresh_request_throttle verification clean");
    end else begin
      $display("refresh_request_throttle verification failed");
    end
    $finish;
  end

endmodule
